[rtl/dpb_pkg.sv]
// Shared types and constants for the depth pixel back-projection block.
// No dependencies; imported by every module of the block.
package dpb_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COUNT_LIMIT = 4096;

    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int PHASE_W = 8;
    localparam int DEPTH_W = 32;
    localparam int Z_W     = 31;
    localparam int COORD_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 120;

    localparam int WIDTH_LIMIT  = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;
    localparam int HEIGHT_LIMIT = (MAX_HEIGHT < COUNT_LIMIT) ? MAX_HEIGHT : COUNT_LIMIT;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STRIDE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_FOCAL_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECIP_FOCAL_Y = 3'd6;

    typedef struct packed {
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [PHASE_W-1:0] sample_stride;
        logic [15:0]        center_x;
        logic [15:0]        center_y;
        logic [31:0]        recip_focal_x;
        logic [31:0]        recip_focal_y;
    } cfg_t;

    // kept pixel handed from front to back
    typedef struct packed {
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
        logic [Z_W-1:0]   depth;
    } pixel_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

endpackage

[rtl/dpb_front.sv]
// Front end: raster counters, subsampling grid and depth check.
// Depends on dpb_pkg.
module dpb_front
    import dpb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 accept,
    input  logic [DEPTH_W-1:0]   depth_value,
    input  logic                 depth_finite,
    output logic                 keep,
    output pixel_t               pixel
);

    logic [POS_W-1:0]   column_count_reg, column_count_next;
    logic [POS_W-1:0]   row_count_reg, row_count_next;
    logic [PHASE_W-1:0] column_phase_reg, column_phase_next;
    logic [PHASE_W-1:0] row_phase_reg, row_phase_next;

    logic [SIZE_W-1:0]  width_eff;
    logic [SIZE_W-1:0]  height_eff;
    logic [PHASE_W-1:0] stride_eff;
    logic [SIZE_W-1:0]  column_inc;
    logic [SIZE_W-1:0]  row_inc;
    logic [PHASE_W:0]   column_phase_inc;
    logic [PHASE_W:0]   row_phase_inc;

    always_comb
    begin
        width_eff = (cfg.image_width == '0) ? SIZE_W'(1) : cfg.image_width;
        if (width_eff > SIZE_W'(WIDTH_LIMIT))
        begin
            width_eff = SIZE_W'(WIDTH_LIMIT);
        end
        height_eff = (cfg.image_height == '0) ? SIZE_W'(1) : cfg.image_height;
        if (height_eff > SIZE_W'(HEIGHT_LIMIT))
        begin
            height_eff = SIZE_W'(HEIGHT_LIMIT);
        end
        stride_eff = (cfg.sample_stride == '0) ? PHASE_W'(1) : cfg.sample_stride;
    end

    assign column_inc       = {1'b0, column_count_reg} + SIZE_W'(1);
    assign row_inc          = {1'b0, row_count_reg} + SIZE_W'(1);
    assign column_phase_inc = {1'b0, column_phase_reg} + (PHASE_W+1)'(1);
    assign row_phase_inc    = {1'b0, row_phase_reg} + (PHASE_W+1)'(1);

    assign keep = (column_phase_reg == '0) && (row_phase_reg == '0) && depth_finite
                  && !depth_value[DEPTH_W-1] && (depth_value != '0);

    assign pixel.column = column_count_reg;
    assign pixel.row    = row_count_reg;
    assign pixel.depth  = depth_value[Z_W-1:0];

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        column_phase_next = column_phase_reg;
        row_phase_next    = row_phase_reg;
        if (accept)
        begin
            if (column_inc >= width_eff)
            begin
                column_count_next = '0;
                column_phase_next = '0;
                if (row_inc >= height_eff)
                begin
                    row_count_next = '0;
                    row_phase_next = '0;
                end
                else
                begin
                    row_count_next = row_inc[POS_W-1:0];
                    row_phase_next = (row_phase_inc >= {1'b0, stride_eff}) ? '0
                                     : row_phase_inc[PHASE_W-1:0];
                end
            end
            else
            begin
                column_count_next = column_inc[POS_W-1:0];
                column_phase_next = (column_phase_inc >= {1'b0, stride_eff}) ? '0
                                    : column_phase_inc[PHASE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            column_phase_reg <= '0;
            row_phase_reg    <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            column_phase_reg <= column_phase_next;
            row_phase_reg    <= row_phase_next;
        end
    end

endmodule

[rtl/dpb_queue.sv]
// Short queue of kept pixels between the front end and the projection pipe.
// Depends on dpb_pkg.
module dpb_queue
    import dpb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  pixel_t push_data,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output pixel_t head
);

    pixel_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;
    logic               do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/dpb_project.sv]
// One coordinate of the projection: (16*pos - center) * z * recip / 2^36,
// rounded half away from zero and saturated. Four stages. Depends on dpb_pkg.
module dpb_project
    import dpb_pkg::*;
(
    input  logic               clk,
    input  pipe_en_t           en,
    input  logic [POS_W-1:0]   pos,
    input  logic [15:0]        center,
    input  logic [31:0]        recip,
    input  logic [Z_W-1:0]     z,
    output logic [COORD_W-1:0] result
);

    logic [16:0] diff;
    logic [15:0] mag_d_reg;
    logic        neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [46:0] m_reg;
    logic [62:0] hi_reg;
    logic [62:0] lo_reg;
    logic [63:0] sum_reg;
    logic [43:0] mag;
    logic [16:0] neg_diff;

    assign diff     = {1'b0, pos, 4'b0} - {1'b0, center};
    assign neg_diff = 17'd0 - diff;
    assign mag      = sum_reg[63:20];

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            neg1_reg  <= diff[16];
            mag_d_reg <= diff[16] ? neg_diff[15:0] : diff[15:0];
        end
        if (en.s2)
        begin
            neg2_reg <= neg1_reg;
            m_reg    <= 47'(mag_d_reg) * 47'(z);
        end
        if (en.s3)
        begin
            neg3_reg <= neg2_reg;
            hi_reg   <= 63'(m_reg) * 63'(recip[31:16]);
            lo_reg   <= 63'(m_reg) * 63'(recip[15:0]);
        end
        if (en.s4)
        begin
            neg4_reg <= neg3_reg;
            sum_reg  <= {1'b0, hi_reg} + 64'(lo_reg[62:16]) + (64'd1 << 19);
        end
    end

    always_comb
    begin
        if (neg4_reg)
        begin
            result = (mag >= 44'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
        end
        else
        begin
            result = (mag > 44'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end
    end

endmodule

[rtl/dpb_back.sv]
// Back end: elastic projection pipe from the queue head to the output register.
// Depends on dpb_pkg and dpb_project.
module dpb_back
    import dpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  head_valid,
    input  pixel_t                head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic     v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    pixel_t   p1_reg, p2_reg, p3_reg, p4_reg;
    pipe_en_t en;
    logic     en_out;
    logic [COORD_W-1:0] x_val, y_val;
    logic [COORD_W-1:0] x_reg, y_reg;
    pixel_t   po_reg;

    assign en_out = !out_valid_reg || out_ready;
    assign en.s4  = !v4_reg || en_out;
    assign en.s3  = !v3_reg || en.s4;
    assign en.s2  = !v2_reg || en.s3;
    assign en.s1  = !v1_reg || en.s2;
    assign pop    = en.s1 && head_valid;

    dpb_project u_proj_x (
        .clk    (clk),
        .en     (en),
        .pos    (head.column),
        .center (cfg.center_x),
        .recip  (cfg.recip_focal_x),
        .z      (p1_reg.depth),
        .result (x_val)
    );

    dpb_project u_proj_y (
        .clk    (clk),
        .en     (en),
        .pos    (head.row),
        .center (cfg.center_y),
        .recip  (cfg.recip_focal_y),
        .z      (p1_reg.depth),
        .result (y_val)
    );

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            p1_reg <= head;
        end
        if (en.s2)
        begin
            p2_reg <= p1_reg;
        end
        if (en.s3)
        begin
            p3_reg <= p2_reg;
        end
        if (en.s4)
        begin
            p4_reg <= p3_reg;
        end
        if (en_out)
        begin
            x_reg  <= x_val;
            y_reg  <= y_val;
            po_reg <= p4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
            begin
                v1_reg <= head_valid;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.s4)
            begin
                v4_reg <= v3_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v4_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {1'b0, po_reg.row, po_reg.column, po_reg.depth, y_reg, x_reg};

endmodule

[rtl/depth_pixel_backprojection.sv]
// Top level of the depth pixel back-projection block: configuration registers,
// front end, queue and projection back end. Depends on dpb_pkg and all dpb_ modules.
//
// channel  dir  signals                       word layout, low bit first
// s_       in   s_tvalid s_tready s_tdata     depth_value[31:0]
//                        s_tuser              depth_finite[0]
// m_       out  m_tvalid m_tready m_tdata     point_x[31:0] point_y[63:32] point_z[94:64]
//                                             pixel_column[106:95] pixel_row[118:107] pad
// cfg_     in   cfg_we cfg_index cfg_data     register value, low bits
//
// One input word per cycle is taken while the four-entry queue has room.
// A kept pixel enters the queue when its word is accepted; the pop loads the first
// of four pipe stages, and the last stage feeds the output register that drives
// m_tdata.
// rst_n clears counters, queue and pipe valids and loads the default registers.
// m_tready low holds the pipe; the queue then fills and s_tready drops.
module depth_pixel_backprojection
    import dpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DEPTH_W-1:0]    s_tdata,   // depth_value
    input  logic [0:0]            s_tuser,   // depth_finite
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // point_x, point_y, point_z, pixel_column, pixel_row
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t   cfg_reg;
    logic   accept;
    logic   keep;
    pixel_t pixel;
    logic   queue_full;
    logic   queue_not_empty;
    pixel_t queue_head;
    logic   queue_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width   <= SIZE_W'(640);
            cfg_reg.image_height  <= SIZE_W'(480);
            cfg_reg.sample_stride <= PHASE_W'(1);
            cfg_reg.center_x      <= 16'd5120;
            cfg_reg.center_y      <= 16'd3840;
            cfg_reg.recip_focal_x <= 32'd8589934;
            cfg_reg.recip_focal_y <= 32'd8589934;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[SIZE_W-1:0];
                REG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data[SIZE_W-1:0];
                REG_SAMPLE_STRIDE: cfg_reg.sample_stride <= cfg_data[PHASE_W-1:0];
                REG_CENTER_X:      cfg_reg.center_x      <= cfg_data[15:0];
                REG_CENTER_Y:      cfg_reg.center_y      <= cfg_data[15:0];
                REG_RECIP_FOCAL_X: cfg_reg.recip_focal_x <= cfg_data;
                REG_RECIP_FOCAL_Y: cfg_reg.recip_focal_y <= cfg_data;
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    dpb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .depth_value  (s_tdata),
        .depth_finite (s_tuser[0]),
        .keep         (keep),
        .pixel        (pixel)
    );

    dpb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && keep),
        .push_data (pixel),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    dpb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (queue_not_empty),
        .head       (queue_head),
        .pop        (queue_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata)
    );

endmodule
